### rtl/core/ipr_pkg.sv
// Package for the address range to prefix block converter.
// Holds the fixed payload widths and the queue depth; no dependencies.
`default_nettype none

package ipr_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned PLEN_W  = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [PLEN_W-1:0]  plen_t;

endpackage

`default_nettype wire

### rtl/core/ipr_range_if.sv
// Valid/ready channel carrying one inclusive address range per beat.
// Depends on ipr_pkg.
`default_nettype none

interface ipr_range_if;
    logic            valid;
    logic            ready;
    ipr_pkg::field_t range_first;
    ipr_pkg::field_t range_last;

    modport source (output valid, output range_first, output range_last, input ready);
    modport sink   (input valid, input range_first, input range_last, output ready);
endinterface

`default_nettype wire

### rtl/core/ipr_block_if.sv
// Valid/ready channel carrying one prefix block per beat.
// Depends on ipr_pkg.
`default_nettype none

interface ipr_block_if;
    logic            valid;
    logic            ready;
    ipr_pkg::field_t block_base;
    ipr_pkg::plen_t  prefix_len;
    logic            last_block;

    modport source (output valid, output block_base, output prefix_len, output last_block,
                    input ready);
    modport sink   (input valid, input block_base, input prefix_len, input last_block,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/ipr_front.sv
// Front end: accepts ranges, masks them to the address width, drops empty
// ranges and queues the rest for the walker. Depends on ipr_pkg, ipr_range_if.
`default_nettype none

module ipr_front #(
    parameter int unsigned AW = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ipr_range_if.sink    rng,
    output logic         q_valid,
    output logic [AW-1:0] q_first,
    output logic [AW-1:0] q_last,
    input  wire logic    q_pop
);

    localparam int unsigned DEPTH = ipr_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [AW-1:0] first_mem [DEPTH];
    logic [AW-1:0] last_mem  [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic [AW+ipr_pkg::FIELD_W-1:0] first_ext;
    logic [AW+ipr_pkg::FIELD_W-1:0] last_ext;
    logic [AW-1:0] first_m;
    logic [AW-1:0] last_m;
    logic          is_empty;
    logic          push;
    logic          pop;

    assign first_ext = {{AW{1'b0}}, rng.range_first};
    assign last_ext  = {{AW{1'b0}}, rng.range_last};
    assign first_m   = first_ext[AW-1:0];
    assign last_m    = last_ext[AW-1:0];
    assign is_empty  = last_m < first_m;

    assign rng.ready = count_reg != CW'(DEPTH);
    assign push      = rng.valid && rng.ready && !is_empty;
    assign pop       = q_pop && q_valid;

    assign q_valid = count_reg != '0;
    assign q_first = first_mem[rd_ptr_reg];
    assign q_last  = last_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            first_mem[wr_ptr_reg] <= first_m;
            last_mem[wr_ptr_reg]  <= last_m;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipr_back.sv
// Back end (depends on ipr_pkg, ipr_block_if): walks one queued range and,
// each unstalled cycle, registers the largest aligned block that fits.
`default_nettype none

module ipr_back #(
    parameter int unsigned AW = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_valid,
    input  wire logic [AW-1:0] q_first,
    input  wire logic [AW-1:0] q_last,
    output logic          q_pop,
    ipr_block_if.source   blk
);

    localparam int unsigned KW = $clog2(AW + 1);

    logic          busy_reg, busy_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] top_reg, top_next;
    logic          oval_reg, oval_next;
    ipr_pkg::field_t obase_reg, obase_next;
    ipr_pkg::plen_t  oplen_reg, oplen_next;
    logic          olast_reg, olast_next;

    logic [AW-1:0] diff;
    logic [AW:0]   diff_p1;
    logic [KW-1:0] tz;
    logic [KW-1:0] lg;
    logic [KW-1:0] k;
    logic [KW-1:0] plen;
    logic [AW:0]   span_w;
    logic [AW-1:0] blk_top;
    logic          done;
    logic          adv;
    logic [AW+ipr_pkg::FIELD_W-1:0] base_ext;
    logic [KW+ipr_pkg::PLEN_W-1:0]  plen_ext;

    // alignment of the cursor and size limit from the remaining span
    always_comb
    begin
        diff    = top_reg - cur_reg;
        diff_p1 = {1'b0, diff} + 1'b1;
        tz = KW'(AW);
        for (int i = AW - 1; i >= 0; i--)
        begin
            if (cur_reg[i])
            begin
                tz = KW'(i);
            end
        end
        lg = '0;
        for (int i = 0; i <= AW; i++)
        begin
            if (diff_p1[i])
            begin
                lg = KW'(i);
            end
        end
        k       = (tz < lg) ? tz : lg;
        plen    = KW'(AW) - k;
        span_w  = ((AW+1)'(1) << k) - 1'b1;
        blk_top = cur_reg + span_w[AW-1:0];
        done    = blk_top == top_reg;
    end

    assign base_ext = {{ipr_pkg::FIELD_W{1'b0}}, cur_reg};
    assign plen_ext = {{ipr_pkg::PLEN_W{1'b0}}, plen};
    assign adv      = !oval_reg || blk.ready;
    assign q_pop    = !busy_reg && q_valid;

    always_comb
    begin
        busy_next  = busy_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        oval_next  = oval_reg && !blk.ready;
        obase_next = obase_reg;
        oplen_next = oplen_reg;
        olast_next = olast_reg;
        if (!busy_reg)
        begin
            if (q_valid)
            begin
                busy_next = 1'b1;
                cur_next  = q_first;
                top_next  = q_last;
            end
        end
        else if (adv)
        begin
            oval_next  = 1'b1;
            obase_next = base_ext[ipr_pkg::FIELD_W-1:0];
            oplen_next = plen_ext[ipr_pkg::PLEN_W-1:0];
            olast_next = done;
            busy_next  = !done;
            cur_next   = blk_top + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        top_reg   <= top_next;
        obase_reg <= obase_next;
        oplen_reg <= oplen_next;
        olast_reg <= olast_next;
    end

    assign blk.valid      = oval_reg;
    assign blk.block_base = obase_reg;
    assign blk.prefix_len = oplen_reg;
    assign blk.last_block = olast_reg;

endmodule

`default_nettype wire

### rtl/core/ip_range_to_prefix_blocks.sv
// Top level of the address range to prefix block converter.
// Depends on ipr_pkg, ipr_range_if, ipr_block_if, ipr_front, ipr_back.
//
// Each accepted range [range_first, range_last] yields its minimal cover of
// aligned prefix blocks in ascending order, the final one marked by
// last_block; a range whose last address is below its first is accepted and
// yields nothing. Input bits above ADDR_WIDTH are ignored. Ranges pass
// through a two-entry queue, so up to two can be taken while the walker is
// busy. The walker loads a range, then makes a single prefix selection and
// emits one block per cycle while the output is not stalled.
`default_nettype none

module ip_range_to_prefix_blocks #(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ipr_range_if.sink   rng,
    ipr_block_if.source blk
);

    logic                  q_valid;
    logic [ADDR_WIDTH-1:0] q_first;
    logic [ADDR_WIDTH-1:0] q_last;
    logic                  q_pop;

    ipr_front #(
        .AW (ADDR_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rng     (rng),
        .q_valid (q_valid),
        .q_first (q_first),
        .q_last  (q_last),
        .q_pop   (q_pop)
    );

    ipr_back #(
        .AW (ADDR_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_first (q_first),
        .q_last  (q_last),
        .q_pop   (q_pop),
        .blk     (blk)
    );

endmodule

`default_nettype wire

### rtl/core/ipr_checker.sv
// Port-level checks for ip_range_to_prefix_blocks, bound to the top level.
// Depends on ipr_pkg.
`default_nettype none

module ipr_checker #(
    parameter int unsigned AW = 32
) (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire ipr_pkg::field_t block_base,
    input wire ipr_pkg::plen_t  prefix_len,
    input wire logic            last_block
);

    logic            mid_reg;
    ipr_pkg::field_t exp_reg;
    logic [63:0]     span_mask;
    logic [63:0]     span_one;

    always_comb
    begin
        span_one  = 64'd1 << (7'(AW) - 7'(prefix_len));
        span_mask = span_one - 64'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= 1'b0;
            exp_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            mid_reg <= !last_block;
            exp_reg <= block_base + span_mask[ipr_pkg::FIELD_W-1:0] + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_base)
            && $stable(prefix_len) && $stable(last_block))
        else $error("block beat changed while stalled");

    a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(prefix_len) <= AW)
        else $error("prefix length beyond address width");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (block_base & span_mask[ipr_pkg::FIELD_W-1:0]) == '0)
        else $error("block base not aligned to its prefix");

    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_reg |-> block_base == exp_reg)
        else $error("block does not follow the previous one");

    a_last_plen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_reg && prefix_len == '0 |-> 1'b0)
        else $error("whole-space block inside a run");

endmodule

bind ip_range_to_prefix_blocks ipr_checker #(
    .AW (ADDR_WIDTH)
) u_ipr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (blk.valid),
    .out_ready  (blk.ready),
    .block_base (blk.block_base),
    .prefix_len (blk.prefix_len),
    .last_block (blk.last_block)
);

`default_nettype wire
